/* rtl/core/phfp_pkg.sv */
package phfp_pkg;

  typedef enum logic [4:0] {
    SEC_FLAGS   = 5'd0,
    SEC_PTS     = 5'd1,
    SEC_DTS     = 5'd2,
    SEC_ESCR    = 5'd3,
    SEC_ESRATE  = 5'd4,
    SEC_TRICK   = 5'd5,
    SEC_COPY    = 5'd6,
    SEC_CRC     = 5'd7,
    SEC_EXTF    = 5'd8,
    SEC_PRIV    = 5'd9,
    SEC_PACKLEN = 5'd10,
    SEC_PACK    = 5'd11,
    SEC_SEQ     = 5'd12,
    SEC_PSTD    = 5'd13,
    SEC_EXT2LEN = 5'd14,
    SEC_EXT2    = 5'd15,
    SEC_PAYLOAD = 5'd16
  } sect_e;

  typedef enum logic [4:0] {
    KIND_FLAGS     = 5'd0,
    KIND_PTS       = 5'd1,
    KIND_DTS       = 5'd2,
    KIND_ESCR_BASE = 5'd3,
    KIND_ESCR_EXT  = 5'd4,
    KIND_ES_RATE   = 5'd5,
    KIND_TRICK     = 5'd6,
    KIND_COPY      = 5'd7,
    KIND_CRC       = 5'd8,
    KIND_EXT_FLAGS = 5'd9,
    KIND_PRIV      = 5'd10,
    KIND_PACK      = 5'd11,
    KIND_SEQ       = 5'd12,
    KIND_PSTD      = 5'd13,
    KIND_EXT2      = 5'd14,
    KIND_PAYLOAD   = 5'd15,
    KIND_TRUNC     = 5'd16
  } kind_e;

  localparam int NumSect = 17;
  localparam int AccW    = 48;
  localparam int ValW    = 33;
  localparam int QDepth  = 4;
  localparam int QAw     = $clog2(QDepth);

  localparam logic [7:0] PrivLen = 8'd16;

  // one queue entry: field kind, raw shifted bytes, end-of-packet mark
  typedef struct packed {
    kind_e             kind;
    logic [AccW-1:0]   raw;
    logic              last;
  } qent_t;

  function automatic logic [NumSect-1:0] sect_enables(logic [15:0] hf, logic [7:0] ef_raw,
                                                      logic [7:0] vl);
    logic [NumSect-1:0] en;
    logic [7:0]         ef;
    ef = hf[0] ? ef_raw : 8'h00;
    en = '0;
    en[SEC_FLAGS]   = 1'b0;
    en[SEC_PTS]     = hf[7];
    en[SEC_DTS]     = hf[7] & hf[6];
    en[SEC_ESCR]    = hf[5];
    en[SEC_ESRATE]  = hf[4];
    en[SEC_TRICK]   = hf[3];
    en[SEC_COPY]    = hf[2];
    en[SEC_CRC]     = hf[1];
    en[SEC_EXTF]    = hf[0];
    en[SEC_PRIV]    = ef[7];
    en[SEC_PACKLEN] = ef[6];
    en[SEC_PACK]    = ef[6] & (vl != 8'd0);
    en[SEC_SEQ]     = ef[5];
    en[SEC_PSTD]    = ef[4];
    en[SEC_EXT2LEN] = ef[0];
    en[SEC_EXT2]    = ef[0] & (vl != 8'd0);
    en[SEC_PAYLOAD] = 1'b1;
    return en;
  endfunction

  function automatic sect_e next_sect(sect_e s, logic [NumSect-1:0] en);
    sect_e n;
    n = SEC_PAYLOAD;
    for (int i = NumSect - 1; i >= 1; i--) begin
      if ((i > int'(s)) && en[i]) begin
        n = sect_e'(i[4:0]);
      end
    end
    return n;
  endfunction

  function automatic kind_e pend_kind(sect_e s);
    kind_e k;
    unique case (s) inside
      SEC_FLAGS:             k = KIND_FLAGS;
      SEC_PTS:               k = KIND_PTS;
      SEC_DTS:               k = KIND_DTS;
      SEC_ESCR:              k = KIND_ESCR_BASE;
      SEC_ESRATE:            k = KIND_ES_RATE;
      SEC_TRICK:             k = KIND_TRICK;
      SEC_COPY:              k = KIND_COPY;
      SEC_CRC:               k = KIND_CRC;
      SEC_EXTF:              k = KIND_EXT_FLAGS;
      SEC_PRIV:              k = KIND_PRIV;
      SEC_PACKLEN, SEC_PACK: k = KIND_PACK;
      SEC_SEQ:               k = KIND_SEQ;
      SEC_PSTD:              k = KIND_PSTD;
      SEC_EXT2LEN, SEC_EXT2: k = KIND_EXT2;
      default:               k = KIND_PAYLOAD;
    endcase
    return k;
  endfunction

endpackage

/* rtl/core/phfp_if.sv */
interface pes_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface pes_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  field_kind;
  logic [32:0] field_value;
  logic        packet_end;

  modport source (output valid, field_kind, field_value, packet_end, input ready);
  modport sink   (input valid, field_kind, field_value, packet_end, output ready);
endinterface

/* rtl/core/phfp_front.sv */
module phfp_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pes_in_if.sink                in_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output phfp_pkg::qent_t       q_entry_o,
  output phfp_pkg::sect_e       sect_o
);

  phfp_pkg::sect_e                sect_q, sect_d;
  logic [7:0]                     cnt_q, cnt_d;
  logic [phfp_pkg::AccW-1:0]      acc_q, acc_d;
  logic [15:0]                    hf_q, hf_d;
  logic [7:0]                     ef_q, ef_d;
  logic [7:0]                     vl_q, vl_d;

  logic                           accept;
  logic [7:0]                     bc;
  logic [phfp_pkg::AccW-1:0]      acc;
  logic                           has;
  logic                           done;
  phfp_pkg::kind_e                kind;
  logic [phfp_pkg::AccW-1:0]      raw;
  logic [phfp_pkg::NumSect-1:0]   en;

  assign in_i.ready = ~q_full_i;
  assign accept     = in_i.valid & ~q_full_i;

  always_comb begin
    bc     = cnt_q + 8'd1;
    acc    = {acc_q[phfp_pkg::AccW-9:0], in_i.data_byte};
    hf_d   = hf_q;
    ef_d   = ef_q;
    vl_d   = vl_q;
    has    = 1'b0;
    done   = 1'b0;
    kind   = phfp_pkg::KIND_FLAGS;
    cnt_d  = bc;
    unique case (sect_q) inside
      phfp_pkg::SEC_FLAGS: begin
        if (bc == 8'd3) begin
          hf_d = acc[23:8];
          has  = 1'b1;
          kind = phfp_pkg::KIND_FLAGS;
          done = 1'b1;
        end
      end
      phfp_pkg::SEC_PTS, phfp_pkg::SEC_DTS: begin
        if (bc == 8'd5) begin
          has  = 1'b1;
          kind = (sect_q == phfp_pkg::SEC_PTS) ? phfp_pkg::KIND_PTS : phfp_pkg::KIND_DTS;
          done = 1'b1;
        end
      end
      phfp_pkg::SEC_ESCR: begin
        if (bc == 8'd5) begin
          has  = 1'b1;
          kind = phfp_pkg::KIND_ESCR_BASE;
        end else if (bc == 8'd6) begin
          has  = 1'b1;
          kind = phfp_pkg::KIND_ESCR_EXT;
          done = 1'b1;
        end
      end
      phfp_pkg::SEC_ESRATE: begin
        if (bc == 8'd3) begin
          has  = 1'b1;
          kind = phfp_pkg::KIND_ES_RATE;
          done = 1'b1;
        end
      end
      phfp_pkg::SEC_TRICK: begin
        has  = 1'b1;
        kind = phfp_pkg::KIND_TRICK;
        done = 1'b1;
      end
      phfp_pkg::SEC_COPY: begin
        has  = 1'b1;
        kind = phfp_pkg::KIND_COPY;
        done = 1'b1;
      end
      phfp_pkg::SEC_CRC, phfp_pkg::SEC_SEQ, phfp_pkg::SEC_PSTD: begin
        if (bc == 8'd2) begin
          has  = 1'b1;
          kind = (sect_q == phfp_pkg::SEC_CRC) ? phfp_pkg::KIND_CRC :
                 (sect_q == phfp_pkg::SEC_SEQ) ? phfp_pkg::KIND_SEQ : phfp_pkg::KIND_PSTD;
          done = 1'b1;
        end
      end
      phfp_pkg::SEC_EXTF: begin
        ef_d = in_i.data_byte;
        has  = 1'b1;
        kind = phfp_pkg::KIND_EXT_FLAGS;
        done = 1'b1;
      end
      phfp_pkg::SEC_PRIV: begin
        has  = 1'b1;
        kind = phfp_pkg::KIND_PRIV;
        done = (bc == phfp_pkg::PrivLen);
      end
      phfp_pkg::SEC_PACKLEN: begin
        vl_d = in_i.data_byte;
        done = 1'b1;
      end
      phfp_pkg::SEC_PACK: begin
        has  = 1'b1;
        kind = phfp_pkg::KIND_PACK;
        done = (bc >= vl_q);
      end
      phfp_pkg::SEC_EXT2LEN: begin
        vl_d = {1'b0, in_i.data_byte[6:0]};
        done = 1'b1;
      end
      phfp_pkg::SEC_EXT2: begin
        has  = 1'b1;
        kind = phfp_pkg::KIND_EXT2;
        done = (bc >= vl_q);
      end
      default: begin
        has   = 1'b1;
        kind  = phfp_pkg::KIND_PAYLOAD;
        cnt_d = 8'd0;
      end
    endcase

    en     = phfp_pkg::sect_enables(hf_d, ef_d, vl_d);
    sect_d = sect_q;
    acc_d  = acc;
    raw    = acc;
    if (done) begin
      sect_d = phfp_pkg::next_sect(sect_q, en);
      cnt_d  = 8'd0;
      acc_d  = '0;
    end

    if (in_i.last_byte) begin
      if (sect_d != phfp_pkg::SEC_PAYLOAD) begin
        has  = 1'b1;
        kind = phfp_pkg::KIND_TRUNC;
        raw  = {{(phfp_pkg::AccW-5){1'b0}}, phfp_pkg::pend_kind(sect_d)};
      end
      sect_d = phfp_pkg::SEC_FLAGS;
      cnt_d  = 8'd0;
      acc_d  = '0;
      hf_d   = 16'd0;
      ef_d   = 8'd0;
      vl_d   = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sect_q <= phfp_pkg::SEC_FLAGS;
      cnt_q  <= 8'd0;
      acc_q  <= '0;
      hf_q   <= 16'd0;
      ef_q   <= 8'd0;
      vl_q   <= 8'd0;
    end else if (accept) begin
      sect_q <= sect_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
      hf_q   <= hf_d;
      ef_q   <= ef_d;
      vl_q   <= vl_d;
    end
  end

  assign q_push_o       = accept & has;
  assign q_entry_o.kind = kind;
  assign q_entry_o.raw  = raw;
  assign q_entry_o.last = in_i.last_byte;
  assign sect_o         = sect_q;

endmodule

/* rtl/core/phfp_queue.sv */
module phfp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  phfp_pkg::qent_t   entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output phfp_pkg::qent_t   head_o
);

  phfp_pkg::qent_t             mem_q [phfp_pkg::QDepth];
  logic [phfp_pkg::QAw-1:0]    wr_q, wr_d;
  logic [phfp_pkg::QAw-1:0]    rd_q, rd_d;
  logic [phfp_pkg::QAw:0]      cnt_q, cnt_d;

  assign full_o  = (cnt_q == (phfp_pkg::QAw+1)'(phfp_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

/* rtl/core/phfp_back.sv */
module phfp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  phfp_pkg::qent_t   q_head_i,
  output logic              q_pop_o,
  pes_out_if.source         out_o
);

  logic                        valid_q, valid_d;
  logic [4:0]                  kind_q;
  logic [phfp_pkg::ValW-1:0]   value_q, value_d;
  logic                        end_q;
  logic [phfp_pkg::AccW-1:0]   a;

  assign q_pop_o = q_valid_i & (~valid_q | out_o.ready);
  assign a       = q_head_i.raw;

  always_comb begin
    value_d = '0;
    unique case (q_head_i.kind) inside
      phfp_pkg::KIND_FLAGS:
        value_d = {9'd0, a[23:0]};
      phfp_pkg::KIND_PTS, phfp_pkg::KIND_DTS:
        value_d = {a[35:33], a[31:17], a[15:1]};
      phfp_pkg::KIND_ESCR_BASE:
        value_d = {a[37:35], a[33:19], a[17:3]};
      phfp_pkg::KIND_ESCR_EXT:
        value_d = {24'd0, a[9:1]};
      phfp_pkg::KIND_ES_RATE:
        value_d = {11'd0, a[22:1]};
      phfp_pkg::KIND_COPY:
        value_d = {26'd0, a[6:0]};
      phfp_pkg::KIND_CRC, phfp_pkg::KIND_SEQ, phfp_pkg::KIND_PSTD:
        value_d = {17'd0, a[15:0]};
      phfp_pkg::KIND_TRUNC:
        value_d = {28'd0, a[4:0]};
      default:
        value_d = {25'd0, a[7:0]};
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (q_pop_o) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      kind_q  <= q_head_i.kind;
      value_q <= value_d;
      end_q   <= q_head_i.last;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.field_kind  = kind_q;
  assign out_o.field_value = value_q;
  assign out_o.packet_end  = end_q;

endmodule

/* rtl/core/pes_header_field_parser_top.sv */
// A result enters the queue with the transfer of the byte that completes it and reaches out_o
// through the output register. Throughput: one byte per cycle while the queue is not full, set
// by the combinational parse step in the front end. A 4-entry queue and the output register
// absorb output stalls; in_i.ready drops only when the queue is full. Reset (rst_ni low, async)
// returns the parser to the header flags section with counters, flags and queue cleared.
module pes_header_field_parser_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  pes_in_if.sink     in_i,
  pes_out_if.source  out_o
);

  logic              q_full;
  logic              q_push;
  phfp_pkg::qent_t   q_entry;
  logic              q_pop;
  logic              q_valid;
  phfp_pkg::qent_t   q_head;
  phfp_pkg::sect_e   sect;

  phfp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_entry_o (q_entry),
    .sect_o    (sect)
  );

  phfp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  phfp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.last_byte) |=> (sect == phfp_pkg::SEC_FLAGS))
    else $error("parser did not restart after last byte");

  a_trunc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && (q_entry.kind == phfp_pkg::KIND_TRUNC)) |-> q_entry.last)
    else $error("truncated result without last byte");

  a_push_on_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (in_i.valid && in_i.ready))
    else $error("queue push without input transfer");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_valid) |-> (!q_pop))
    else $error("queue pop while empty");

endmodule
